[rtl/core/tmta_pkg.sv]
// Shared types, field layout and constants for the tachometer median-trimmed average unit.
`default_nettype none

package tmta_pkg;

    // Default ring depth and the fixed widths of the stream fields.
    localparam int TMTA_RING_DEPTH = 16;
    localparam int SAMPLE_W        = 16;
    localparam int REQ_W           = 2;
    localparam int STATUS_W        = 3;

    // Input word: req_type in the lowest bits, then sample_freq, padded to 24 bits.
    localparam int IN_REQ_LSB  = 0;
    localparam int IN_FREQ_LSB = IN_REQ_LSB + REQ_W;
    localparam int IN_USED_W   = IN_FREQ_LSB + SAMPLE_W;
    localparam int IN_W        = ((IN_USED_W + 7) / 8) * 8;

    // Output word: status, average_freq, last_freq, padded to 40 bits.
    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_AVG_LSB    = OUT_STATUS_LSB + STATUS_W;
    localparam int OUT_LAST_LSB   = OUT_AVG_LSB + SAMPLE_W;
    localparam int OUT_USED_W     = OUT_LAST_LSB + SAMPLE_W;
    localparam int OUT_W          = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W      = OUT_W - OUT_USED_W;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // Configuration register reset values.
    localparam logic [CFG_W-1:0] UPPER_LIMIT_RST = 16'd32000;
    localparam logic [CFG_W-1:0] LOWER_LIMIT_RST = 16'd0;
    localparam logic [CFG_W-1:0] DEVIATION_RST   = 16'd80;
    localparam logic [CFG_W-1:0] AVG_LIMIT_RST   = 16'd16000;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_ACCEPTED      = 3'd0,
        STATUS_AVG_VALID     = 3'd1,
        STATUS_NOT_FULL_ZERO = 3'd2,
        STATUS_NOT_ENOUGH    = 3'd3,
        STATUS_HELD_PREVIOUS = 3'd4
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPPER_LIMIT = 2'd0,
        CFG_LOWER_LIMIT = 2'd1,
        CFG_DEVIATION   = 2'd2,
        CFG_AVG_LIMIT   = 2'd3
    } cfg_idx_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic sel_init;
        logic add;
        logic clear;
        logic rd_probe;
        logic rd_sel;
        logic rd_avg;
        logic sel_decide;
        logic div_init;
        logic div_step;
        logic res_accept;
        logic res_probe;
        logic res_final;
        logic out_load;
    } tmta_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic sel_last;
        logic out_free;
    } tmta_stat_t;

endpackage

`default_nettype wire

[rtl/core/tmta_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module tmta_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/tmta_ctrl.sv]
// Controller state machine that sequences the add, clear, probe, median select, average and divide steps.
`default_nettype none

module tmta_ctrl #(
    parameter int RING_DEPTH = tmta_pkg::TMTA_RING_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [tmta_pkg::REQ_W-1:0]    in_req,
    output logic                               in_ready,
    input  wire tmta_pkg::tmta_stat_t          stat,
    output tmta_pkg::tmta_cmd_t                cmd,
    output logic [$clog2(RING_DEPTH)-1:0]      scan_addr
);

    import tmta_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int SW = SAMPLE_W + AW;
    localparam int DW = $clog2(SW);

    typedef enum logic [13:0] {
        S_IDLE       = 14'b00000000000001,
        S_ADD        = 14'b00000000000010,
        S_CLEAR      = 14'b00000000000100,
        S_NOP        = 14'b00000000001000,
        S_PROBE      = 14'b00000000010000,
        S_PROBE_WAIT = 14'b00000000100000,
        S_SEL_SCAN   = 14'b00000001000000,
        S_SEL_DECIDE = 14'b00000010000000,
        S_AVG_SCAN   = 14'b00000100000000,
        S_AVG_DRAIN  = 14'b00001000000000,
        S_DIV_INIT   = 14'b00010000000000,
        S_DIV        = 14'b00100000000000,
        S_FINAL      = 14'b01000000000000,
        S_POST       = 14'b10000000000000
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [AW-1:0]   addr_reg;
    logic [AW-1:0]   addr_next;
    logic [DW-1:0]   div_reg;
    logic [DW-1:0]   div_next;
    logic            addr_end;

    assign addr_end  = (addr_reg == AW'(RING_DEPTH - 1));
    assign scan_addr = addr_reg;

    // Next-state and command decode.
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        div_next   = div_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                addr_next = '0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (in_req)
                        REQ_ADD:
                        begin
                            state_next = S_ADD;
                        end
                        REQ_READ:
                        begin
                            if (stat.full)
                            begin
                                cmd.sel_init = 1'b1;
                                state_next   = S_SEL_SCAN;
                            end
                            else
                            begin
                                state_next = S_PROBE;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_NOP;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                cmd.add        = 1'b1;
                cmd.res_accept = 1'b1;
                state_next     = S_POST;
            end
            S_CLEAR:
            begin
                cmd.clear      = 1'b1;
                cmd.res_accept = 1'b1;
                state_next     = S_POST;
            end
            S_NOP:
            begin
                cmd.res_accept = 1'b1;
                state_next     = S_POST;
            end
            S_PROBE:
            begin
                cmd.rd_probe = 1'b1;
                state_next   = S_PROBE_WAIT;
            end
            S_PROBE_WAIT:
            begin
                cmd.res_probe = 1'b1;
                state_next    = S_POST;
            end
            S_SEL_SCAN:
            begin
                cmd.rd_sel = 1'b1;
                if (addr_end)
                begin
                    addr_next  = '0;
                    state_next = S_SEL_DECIDE;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            S_SEL_DECIDE:
            begin
                cmd.sel_decide = 1'b1;
                state_next     = stat.sel_last ? S_AVG_SCAN : S_SEL_SCAN;
            end
            S_AVG_SCAN:
            begin
                cmd.rd_avg = 1'b1;
                if (addr_end)
                begin
                    addr_next  = '0;
                    state_next = S_AVG_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            S_AVG_DRAIN:
            begin
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                div_next     = DW'(SW - 1);
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_reg == '0)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    div_next = div_reg - DW'(1);
                end
            end
            S_FINAL:
            begin
                cmd.res_final = 1'b1;
                state_next    = S_POST;
            end
            S_POST:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            addr_reg  <= '0;
            div_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            div_reg   <= div_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/tmta_dpath.sv]
// Datapath: configuration registers, sample ring, radix median select, trimmed sum and divider.
`default_nettype none

module tmta_dpath #(
    parameter int RING_DEPTH = tmta_pkg::TMTA_RING_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [tmta_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tmta_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic [tmta_pkg::IN_W-1:0]         in_data,
    input  wire tmta_pkg::tmta_cmd_t               cmd,
    input  wire logic [$clog2(RING_DEPTH)-1:0]     scan_addr,
    output tmta_pkg::tmta_stat_t                   stat,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [tmta_pkg::OUT_W-1:0]             out_data
);

    import tmta_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int SW = SAMPLE_W + AW;

    // Configuration registers.
    logic [CFG_W-1:0] upper_reg;
    logic [CFG_W-1:0] lower_reg;
    logic [CFG_W-1:0] dev_reg;
    logic [CFG_W-1:0] limit_reg;

    // Ring bookkeeping.
    logic [AW-1:0]         wi_reg;
    logic [CW-1:0]         fill_reg;
    logic [RING_DEPTH-1:0] valid_reg;
    logic [SAMPLE_W-1:0]   last_reg;
    logic [SAMPLE_W-1:0]   top_reg;
    logic [SAMPLE_W-1:0]   prev_reg;
    logic [SAMPLE_W-1:0]   freq_reg;
    logic [SAMPLE_W-1:0]   stored;
    logic                  wi_end;

    // Ring read path.
    logic                  rd_en;
    logic [AW-1:0]         raddr;
    logic [SAMPLE_W-1:0]   rdata;
    logic                  vb_reg;
    logic                  tap_sel_reg;
    logic                  tap_avg_reg;
    logic [SAMPLE_W-1:0]   elem;

    // Median select.
    logic [SAMPLE_W-1:0]   prefix_reg;
    logic [SAMPLE_W-1:0]   mask_reg;
    logic [SAMPLE_W-1:0]   bitsel_reg;
    logic [CW-1:0]         rank_reg;
    logic [CW-1:0]         c0_reg;
    logic [CW-1:0]         c0_total;
    logic                  sel_hit;

    // Trimmed sum and divider.
    logic [SW-1:0]         sum_reg;
    logic [CW-1:0]         cnt_reg;
    logic [SAMPLE_W-1:0]   gap;
    logic                  avg_hit;
    logic [SW-1:0]         q_reg;
    logic [CW-1:0]         rem_reg;
    logic [CW:0]           trial;
    logic                  trial_ge;
    logic [SAMPLE_W-1:0]   quo;

    // Result staging and output register.
    status_t               res_status_reg;
    logic [SAMPLE_W-1:0]   res_avg_reg;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_data_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= UPPER_LIMIT_RST;
            lower_reg <= LOWER_LIMIT_RST;
            dev_reg   <= DEVIATION_RST;
            limit_reg <= AVG_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_UPPER_LIMIT: upper_reg <= cfg_data;
                CFG_LOWER_LIMIT: lower_reg <= cfg_data;
                CFG_DEVIATION:   dev_reg   <= cfg_data;
                CFG_AVG_LIMIT:   limit_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Samples outside the band, or on either limit, are stored as zero.
    assign stored = (freq_reg >= upper_reg || freq_reg <= lower_reg) ? '0 : freq_reg;
    assign wi_end = (wi_reg == AW'(RING_DEPTH - 1));

    // Ring storage.
    assign rd_en = cmd.rd_probe | cmd.rd_sel | cmd.rd_avg;
    assign raddr = cmd.rd_probe ? wi_reg : scan_addr;

    tmta_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.add),
        .waddr (wi_reg),
        .wdata (stored),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // An entry never written reads as zero.
    assign elem = vb_reg ? rdata : '0;

    // Median select: count the entries that match the decided prefix and hold zero
    // in the bit under test.
    assign sel_hit  = tap_sel_reg && (((elem ^ prefix_reg) & mask_reg) == '0)
                      && ((elem & bitsel_reg) == '0);
    assign c0_total = c0_reg + CW'(sel_hit);

    // Trimmed average: take every entry within the deviation of the median.
    assign gap     = (elem >= prefix_reg) ? (elem - prefix_reg) : (prefix_reg - elem);
    assign avg_hit = tap_avg_reg && (gap <= dev_reg);

    // Restoring divider step, one quotient bit per cycle.
    assign trial    = {rem_reg, q_reg[SW-1]};
    assign trial_ge = (trial >= {1'b0, cnt_reg});
    assign quo      = q_reg[SAMPLE_W-1:0];

    // Control state of the ring and the read taps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg        <= '0;
            fill_reg      <= '0;
            valid_reg     <= '0;
            last_reg      <= '0;
            top_reg       <= '0;
            prev_reg      <= '0;
            vb_reg        <= 1'b0;
            tap_sel_reg   <= 1'b0;
            tap_avg_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tap_sel_reg <= cmd.rd_sel;
            tap_avg_reg <= cmd.rd_avg;
            if (rd_en)
            begin
                vb_reg <= valid_reg[raddr];
            end
            if (cmd.add)
            begin
                valid_reg[wi_reg] <= 1'b1;
                last_reg          <= stored;
                wi_reg            <= wi_end ? '0 : wi_reg + AW'(1);
                if (fill_reg != CW'(RING_DEPTH))
                begin
                    fill_reg <= fill_reg + CW'(1);
                end
                if (wi_end)
                begin
                    top_reg <= stored;
                end
            end
            if (cmd.clear)
            begin
                wi_reg   <= '0;
                fill_reg <= '0;
                last_reg <= top_reg;
            end
            if (cmd.res_final)
            begin
                prev_reg <= (quo > limit_reg) ? prev_reg : quo;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the select, average and divide passes.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            freq_reg <= in_data[IN_FREQ_LSB +: SAMPLE_W];
        end
        if (cmd.sel_init)
        begin
            prefix_reg <= '0;
            mask_reg   <= '0;
            bitsel_reg <= {1'b1, {(SAMPLE_W-1){1'b0}}};
            rank_reg   <= CW'(RING_DEPTH / 2);
            c0_reg     <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cmd.sel_decide)
            begin
                if (rank_reg >= c0_total)
                begin
                    prefix_reg <= prefix_reg | bitsel_reg;
                    rank_reg   <= rank_reg - c0_total;
                end
                mask_reg   <= mask_reg | bitsel_reg;
                bitsel_reg <= bitsel_reg >> 1;
                c0_reg     <= '0;
            end
            else if (sel_hit)
            begin
                c0_reg <= c0_reg + CW'(1);
            end
            if (avg_hit)
            begin
                sum_reg <= sum_reg + SW'(elem);
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
        if (cmd.div_init)
        begin
            q_reg   <= sum_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            q_reg   <= {q_reg[SW-2:0], trial_ge};
            rem_reg <= trial_ge ? CW'(trial - {1'b0, cnt_reg}) : CW'(trial);
        end
    end

    // Result staging and the output word.
    always_ff @(posedge clk)
    begin
        if (cmd.res_accept)
        begin
            res_status_reg <= STATUS_ACCEPTED;
            res_avg_reg    <= '0;
        end
        if (cmd.res_probe)
        begin
            res_status_reg <= (elem == '0) ? STATUS_NOT_FULL_ZERO : STATUS_NOT_ENOUGH;
            res_avg_reg    <= '0;
        end
        if (cmd.res_final)
        begin
            if (quo > limit_reg)
            begin
                res_status_reg <= STATUS_HELD_PREVIOUS;
                res_avg_reg    <= prev_reg;
            end
            else
            begin
                res_status_reg <= STATUS_AVG_VALID;
                res_avg_reg    <= quo;
            end
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {{OUT_PAD_W{1'b0}}, last_reg, res_avg_reg, res_status_reg};
        end
    end

    assign stat.full     = (fill_reg == CW'(RING_DEPTH));
    assign stat.sel_last = bitsel_reg[0];
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

[rtl/core/tacho_median_trimmed_average_unit.sv]
// Top level of the tachometer median-trimmed average unit.
`default_nettype none

// Keeps a ring of RING_DEPTH tachometer samples (unsigned Q12.4 hertz) and answers add,
// read and clear requests, one result word for each request word. Requests are handled one
// at a time; a finished result waits in the output register while the next request is
// taken. An add, a clear or an unused code passes through its own state to S_POST, and a
// read of a ring that is not yet full goes through S_PROBE and S_PROBE_WAIT to S_POST;
// S_POST holds until the output register is free. A read of a full ring finds the upper
// median by a bit-by-bit radix select that walks the single ring read port once for each
// of the 16 sample bits, then walks it once more for the trimmed sum and divides in a
// one-bit-per-cycle restoring divider. The ring needs no clearing pass: a valid bit per
// entry makes a never-written entry read as zero.
module tacho_median_trimmed_average_unit #(
    parameter int RING_DEPTH = tmta_pkg::TMTA_RING_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Request words.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [1:0] req_type, [17:2] sample_freq, [23:18] zero
    input  wire logic [tmta_pkg::IN_W-1:0]      s_tdata,
    // Result words.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [2:0] status, [18:3] average_freq, [34:19] last_freq, [39:35] zero
    output logic [tmta_pkg::OUT_W-1:0]          m_tdata,
    // Configuration writes.
    input  wire logic                           cfg_we,
    input  wire logic [tmta_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tmta_pkg::CFG_W-1:0]     cfg_data
);

    import tmta_pkg::*;

    tmta_cmd_t                     cmd;
    tmta_stat_t                    stat;
    logic [$clog2(RING_DEPTH)-1:0] scan_addr;

    tmta_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_req    (s_tdata[IN_REQ_LSB +: REQ_W]),
        .in_ready  (s_tready),
        .stat      (stat),
        .cmd       (cmd),
        .scan_addr (scan_addr)
    );

    tmta_dpath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .scan_addr (scan_addr),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

    // A request word never produces its result in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !cmd.out_load)
        else $error("result loaded right after a request was accepted");

    // The output register is only loaded when its word is gone or leaving.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result word overwritten before it was taken");

    // A new result word appears only after a load command.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("result valid rose without a load");

    // The controller takes no request while a ring pass, a divide or an add is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !(cmd.rd_sel || cmd.rd_avg || cmd.div_step || cmd.add))
        else $error("request accepted while the datapath is busy");

endmodule

`default_nettype wire
